>>> hdl/color_key_sprite_blitter_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color key sprite blitter
// Concurrent checks on i_clk, off while i_rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef COLOR_KEY_SPRITE_BLITTER_DEFINES_SVH
`define COLOR_KEY_SPRITE_BLITTER_DEFINES_SVH

`ifndef SYNTHESIS

`define CKSB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

`define CKSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CKSB_ASSERT(lbl, prop, msg)

`define CKSB_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/cksb_pkg.sv
// ----------------------------------------------------------------------------
// cksb_pkg
// Item, configuration and stage types plus register index codes.
// ----------------------------------------------------------------------------
package cksb_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEST_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd5;

    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;

    typedef struct packed {
        logic [7:0] src_blue;
        logic [7:0] src_green;
        logic [7:0] src_red;
        logic [7:0] src_alpha;
    } t_in;

    typedef struct packed {
        logic        write_enable;
        logic [23:0] pixel_index;
        logic [7:0]  out_blue;
        logic [7:0]  out_green;
        logic [7:0]  out_red;
        logic        image_done;
    } t_out;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [11:0] dest_x;
        logic [11:0] dest_y;
        logic [12:0] image_width;
        logic [12:0] image_height;
    } t_cfg;

    // pixel after position tracking; x and y only matter when we is set
    typedef struct packed {
        logic        we;
        logic        done;
        logic [12:0] x;
        logic [12:0] y;
        logic [7:0]  blue;
        logic [7:0]  green;
        logic [7:0]  red;
    } t_mid;

    typedef struct packed {
        logic valid;
        t_mid data;
    } t_mid_bus;

endpackage

>>> hdl/cksb_cfg.sv
// ----------------------------------------------------------------------------
// cksb_cfg
// Configuration register file with a plain indexed write port.
// ----------------------------------------------------------------------------
module cksb_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [cksb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cksb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output cksb_pkg::t_cfg                   o_cfg
);

    cksb_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= cksb_pkg::SCREEN_WIDTH_RST;
            r_cfg.screen_height <= cksb_pkg::SCREEN_HEIGHT_RST;
            r_cfg.dest_x        <= '0;
            r_cfg.dest_y        <= '0;
            r_cfg.image_width   <= 13'd1;
            r_cfg.image_height  <= 13'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                cksb_pkg::CFG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data;
                cksb_pkg::CFG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data;
                cksb_pkg::CFG_DEST_X:        r_cfg.dest_x        <= i_cfg_data[11:0];
                cksb_pkg::CFG_DEST_Y:        r_cfg.dest_y        <= i_cfg_data[11:0];
                cksb_pkg::CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_data;
                cksb_pkg::CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hdl/cksb_track.sv
// ----------------------------------------------------------------------------
// cksb_track
// Column/row counters, clip and color key test, input register stage.
// ----------------------------------------------------------------------------
`include "color_key_sprite_blitter_defines.svh"

module cksb_track #(
    parameter int MAX_DIM = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cksb_pkg::t_cfg   i_cfg,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  cksb_pkg::t_in    i_in_data,
    output cksb_pkg::t_mid_bus o_mid,
    input  logic             i_take
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int WW = (DW > 13) ? DW : 13;
    localparam int XW = ((CW > 12) ? CW : 12) + 1;

    logic [CW-1:0]    r_col, n_col;
    logic [CW-1:0]    r_row, n_row;
    logic             r_valid, n_valid;
    cksb_pkg::t_mid   r_mid, n_mid;

    logic [WW-1:0]    w_clamp, h_clamp;
    logic [WW-1:0]    iw_ext, ih_ext;
    logic [WW-1:0]    col_next, row_next;
    logic [XW-1:0]    xs, ys;
    logic             last_col, last_row, on_screen, accept, can_load;

    always_comb begin
        iw_ext = WW'(i_cfg.image_width);
        ih_ext = WW'(i_cfg.image_height);
        if (iw_ext == '0) begin
            w_clamp = WW'(1);
        end else if (iw_ext > WW'(MAX_DIM)) begin
            w_clamp = WW'(MAX_DIM);
        end else begin
            w_clamp = iw_ext;
        end
        if (ih_ext == '0) begin
            h_clamp = WW'(1);
        end else if (ih_ext > WW'(MAX_DIM)) begin
            h_clamp = WW'(MAX_DIM);
        end else begin
            h_clamp = ih_ext;
        end
    end

    assign col_next = WW'(r_col) + WW'(1);
    assign row_next = WW'(r_row) + WW'(1);
    assign last_col = col_next >= w_clamp;
    assign last_row = row_next >= h_clamp;

    assign xs = XW'(i_cfg.dest_x) + XW'(r_col);
    assign ys = XW'(i_cfg.dest_y) + XW'(r_row);
    assign on_screen = (xs < XW'(i_cfg.screen_width)) && (ys < XW'(i_cfg.screen_height));

    assign can_load   = !r_valid || i_take;
    assign o_in_stall = !can_load;
    assign accept     = i_in_valid && can_load;

    always_comb begin
        n_mid.we    = on_screen && (i_in_data.src_alpha != 8'd0);
        n_mid.done  = last_col && last_row;
        n_mid.x     = xs[12:0];
        n_mid.y     = ys[12:0];
        n_mid.blue  = i_in_data.src_blue;
        n_mid.green = i_in_data.src_green;
        n_mid.red   = i_in_data.src_red;

        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end

        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mid <= n_mid;
        end
    end

    assign o_mid.valid = r_valid;
    assign o_mid.data  = r_mid;

    `CKSB_ASSERT_NEXT(a_wrap_on_done, accept && n_mid.done, r_col == '0 && r_row == '0, "counters did not wrap after last pixel")
    `CKSB_ASSERT(a_take_needs_item, !i_take || r_valid, "item taken from empty stage")
    `CKSB_ASSERT_NEXT(a_hold_item, r_valid && !i_take, r_valid && $stable(r_mid), "held item lost or changed")

endmodule

>>> hdl/cksb_emit.sv
// ----------------------------------------------------------------------------
// cksb_emit
// Framebuffer index multiply-add, blanking of unwritten pixels, result register.
// ----------------------------------------------------------------------------
`include "color_key_sprite_blitter_defines.svh"

module cksb_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [12:0]        i_screen_width,
    input  cksb_pkg::t_mid_bus i_mid,
    output logic               o_take,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cksb_pkg::t_out     o_out_data
);

    logic            r_out_valid, n_out_valid;
    cksb_pkg::t_out  r_out, n_out;
    logic [25:0]     idx;

    assign o_take = i_mid.valid && (!r_out_valid || !i_out_stall);
    assign idx    = ({13'd0, i_mid.data.y} * {13'd0, i_screen_width}) + {13'd0, i_mid.data.x};

    always_comb begin
        n_out.write_enable = i_mid.data.we;
        n_out.image_done   = i_mid.data.done;
        if (i_mid.data.we) begin
            n_out.pixel_index = idx[23:0];
            n_out.out_blue    = i_mid.data.blue;
            n_out.out_green   = i_mid.data.green;
            n_out.out_red     = i_mid.data.red;
        end else begin
            n_out.pixel_index = '0;
            n_out.out_blue    = '0;
            n_out.out_green   = '0;
            n_out.out_red     = '0;
        end

        if (o_take) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `CKSB_ASSERT_NEXT(a_take_loads, o_take, r_out_valid, "taken item not presented")
    `CKSB_ASSERT(a_blank_skip, !r_out_valid || r_out.write_enable || (r_out.pixel_index == '0 && r_out.out_blue == '0 && r_out.out_green == '0 && r_out.out_red == '0), "skipped pixel not blanked")

endmodule

>>> hdl/color_key_sprite_blitter.sv
// ----------------------------------------------------------------------------
// color_key_sprite_blitter
// Color key sprite blit with screen clipping, one source pixel per item.
// ----------------------------------------------------------------------------
// Source pixels arrive in raster order, one per item, and each gives one result:
// a write flag, the framebuffer index (screen y * screen_width + screen x) and the color,
// with the last pixel of the image flagged. Pixels with zero alpha or off screen
// are consumed but not written. Sustained rate is one item per clock while the
// output is not stalled. Items pass through the input register stage (counters,
// clip and key test) and the result register behind the 13x13 index multiply-add.
// Write configuration only while no items are in flight.
module color_key_sprite_blitter #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  cksb_pkg::t_in                    i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output cksb_pkg::t_out                   o_out_data,
    input  logic                             i_cfg_we,
    input  logic [cksb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cksb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    cksb_pkg::t_cfg     cfg;
    cksb_pkg::t_mid_bus mid;
    logic               take;

    cksb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cksb_track #(
        .MAX_DIM (MAX_DIM)
    ) u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_mid      (mid),
        .i_take     (take)
    );

    cksb_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_screen_width (cfg.screen_width),
        .i_mid          (mid),
        .o_take         (take),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_data     (o_out_data)
    );

endmodule
